@@ src/dtbe_pkg.sv @@
// Shared types, codes and calendar helpers for the date and time editor.
// Used by dtbe_edit, dtbe_weekday and date_time_button_editor; no dependencies.
package dtbe_pkg;

   // Widths of the fields.
   localparam int YearW   = 12;
   localparam int MonthW  = 4;
   localparam int DayW    = 5;
   localparam int HourW   = 5;
   localparam int MinuteW = 6;
   localparam int FocusW  = 3;
   localparam int FuncW   = 3;
   localparam int ActionW = 2;
   localparam int WeekdayW = 3;
   localparam int CsrIndexW = 1;
   localparam int CsrDataW  = 12;

   // Reset values of the registers.
   localparam logic [YearW-1:0]   YEAR_LOW_RESET  = 12'd2020;
   localparam logic [YearW-1:0]   YEAR_HIGH_RESET = 12'd2099;
   localparam logic [YearW-1:0]   YEAR_RESET      = 12'd2020;
   localparam logic [MonthW-1:0]  MONTH_RESET     = 4'd1;
   localparam logic [DayW-1:0]    DAY_RESET       = 5'd1;
   localparam logic [HourW-1:0]   HOUR_RESET      = 5'd0;
   localparam logic [MinuteW-1:0] MINUTE_RESET    = 6'd0;

   // Field limits.
   localparam logic [MonthW-1:0]  MONTH_FIRST = 4'd1;
   localparam logic [MonthW-1:0]  MONTH_LAST  = 4'd12;
   localparam logic [DayW-1:0]    DAY_FIRST   = 5'd1;
   localparam logic [HourW-1:0]   HOUR_LAST   = 5'd23;
   localparam logic [MinuteW-1:0] MINUTE_LAST = 6'd59;

   // Button function codes.
   typedef enum logic [FuncW-1:0] {
      FUNC_LEFT  = 3'd0,
      FUNC_RIGHT = 3'd1,
      FUNC_UP    = 3'd2,
      FUNC_DOWN  = 3'd3,
      FUNC_OK    = 3'd4,
      FUNC_BACK  = 3'd5,
      FUNC_LOAD  = 3'd6
   } func_type;

   // Button action codes.
   typedef enum logic [ActionW-1:0] {
      ACT_PRESS   = 2'd0,
      ACT_REPEAT  = 2'd1,
      ACT_RELEASE = 2'd2
   } action_type;

   // Focused field codes.
   typedef enum logic [FocusW-1:0] {
      FOCUS_YEAR   = 3'd0,
      FOCUS_MONTH  = 3'd1,
      FOCUS_DAY    = 3'd2,
      FOCUS_HOUR   = 3'd3,
      FOCUS_MINUTE = 3'd4
   } focus_type;

   // Configuration register indexes.
   typedef enum logic [CsrIndexW-1:0] {
      CSR_YEAR_LOW  = 1'd0,
      CSR_YEAR_HIGH = 1'd1
   } csr_index_type;

   // Date and time fields as one group.
   typedef struct packed {
      logic [YearW-1:0]   year;
      logic [MonthW-1:0]  month;
      logic [DayW-1:0]    day;
      logic [HourW-1:0]   hour;
      logic [MinuteW-1:0] minute;
   } date_time_type;

   // One input transaction.
   typedef struct packed {
      logic [FuncW-1:0]   func;
      logic [ActionW-1:0] action;
      date_time_type      load;
   } req_item_type;

   // Editor state after one transaction, with the pulses it raised.
   typedef struct packed {
      date_time_type     dt;
      logic [FocusW-1:0] focus;
      logic              save;
      logic              leave;
   } edit_result_type;

   // Days in a month; out-of-range months count as 31 days.
   function automatic logic [DayW-1:0] month_days(input logic leap,
                                                  input logic [MonthW-1:0] month);
      logic [DayW-1:0] days;
      case (month)
         4'd2:    days = leap ? 5'd29 : 5'd28;
         4'd4:    days = 5'd30;
         4'd6:    days = 5'd30;
         4'd9:    days = 5'd30;
         4'd11:   days = 5'd30;
         default: days = 5'd31;
      endcase
      return days;
   endfunction

   // Weekday offset of the first day of each month (month-offset table).
   function automatic logic [WeekdayW-1:0] month_offset(input logic [MonthW-1:0] month);
      logic [WeekdayW-1:0] offs;
      case (month)
         4'd2:    offs = 3'd3;
         4'd3:    offs = 3'd2;
         4'd4:    offs = 3'd5;
         4'd6:    offs = 3'd3;
         4'd7:    offs = 3'd5;
         4'd8:    offs = 3'd1;
         4'd9:    offs = 3'd4;
         4'd10:   offs = 3'd6;
         4'd11:   offs = 3'd2;
         4'd12:   offs = 3'd4;
         default: offs = 3'd0;
      endcase
      return offs;
   endfunction

endpackage

@@ src/dtbe_edit.sv @@
// Editor state: the date and time fields, the focus, the year bounds and the
// next-state logic for one button transaction. Depends on dtbe_pkg.
module dtbe_edit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [dtbe_pkg::CsrIndexW-1:0]        csr_index,
   input  logic [dtbe_pkg::CsrDataW-1:0]         csr_wdata,
   input  logic                                  take,
   input  dtbe_pkg::req_item_type                item,
   output dtbe_pkg::edit_result_type             result
);

   // Year bounds.
   logic [dtbe_pkg::YearW-1:0] year_low_ff, year_high_ff;

   // Editor state and pulses of the last transaction.
   dtbe_pkg::date_time_type     dt_ff, dt_in;
   logic [dtbe_pkg::FocusW-1:0] focus_ff, focus_in;
   logic                        save_ff, save_in;
   logic                        leave_ff, leave_in;

   logic                        press, nav, is_load, adj_up, adj;
   logic [dtbe_pkg::YearW:0]    year_inc, year_dec, year_sel;
   logic [dtbe_pkg::YearW-1:0]  year_adj;
   logic [dtbe_pkg::MonthW-1:0] month_adj, load_month;
   logic [dtbe_pkg::YearW-1:0]  year_n;
   logic [dtbe_pkg::MonthW-1:0] month_n;
   logic [dtbe_pkg::YearW-1:0]  div25_prod;
   logic [2*dtbe_pkg::YearW-1:0] div25_full;
   logic                        div25, leap;
   logic [dtbe_pkg::DayW-1:0]   dim, day_base, day_clamp;

   // Decode of the button event.
   assign press   = (item.action == dtbe_pkg::ACT_PRESS);
   assign nav     = press || (item.action == dtbe_pkg::ACT_REPEAT);
   assign is_load = (item.func == dtbe_pkg::FUNC_LOAD);
   assign adj_up  = (item.func == dtbe_pkg::FUNC_UP) && nav;
   assign adj     = adj_up || ((item.func == dtbe_pkg::FUNC_DOWN) && nav);

   // Year step with wrap between the bounds.
   assign year_inc = {1'b0, dt_ff.year} + 13'd1;
   assign year_dec = {1'b0, dt_ff.year} - 13'd1;

   always_comb begin
      if (adj_up) begin
         year_sel = year_inc;
         if (year_sel < {1'b0, year_low_ff}) begin
            year_sel = {1'b0, year_high_ff};
         end
      end else begin
         year_sel = year_dec;
         if ((dt_ff.year == '0) || (year_dec < {1'b0, year_low_ff})) begin
            year_sel = {1'b0, year_high_ff};
         end
      end
      if (year_sel > {1'b0, year_high_ff}) begin
         year_sel = {1'b0, year_low_ff};
      end
   end

   assign year_adj = year_sel[dtbe_pkg::YearW-1:0];

   // Month step with wrap, and clamping of a loaded month.
   always_comb begin
      if (adj_up) begin
         month_adj = (dt_ff.month >= dtbe_pkg::MONTH_LAST) ? dtbe_pkg::MONTH_FIRST
                                                           : dt_ff.month + 4'd1;
      end else begin
         month_adj = (dt_ff.month <= dtbe_pkg::MONTH_FIRST) ? dtbe_pkg::MONTH_LAST
                                                            : dt_ff.month - 4'd1;
      end
      if (item.load.month < dtbe_pkg::MONTH_FIRST) begin
         load_month = dtbe_pkg::MONTH_FIRST;
      end else if (item.load.month > dtbe_pkg::MONTH_LAST) begin
         load_month = dtbe_pkg::MONTH_LAST;
      end else begin
         load_month = item.load.month;
      end
   end

   // Year and month after this transaction.
   always_comb begin
      if (is_load) begin
         year_n  = item.load.year;
         month_n = load_month;
      end else begin
         year_n  = dt_ff.year;
         month_n = dt_ff.month;
         if (adj && (focus_ff == dtbe_pkg::FOCUS_YEAR)) begin
            year_n = year_adj;
         end
         if (adj && (focus_ff == dtbe_pkg::FOCUS_MONTH)) begin
            month_n = month_adj;
         end
      end
   end

   // Leap year test: divisibility by 25 through the modular inverse of 25.
   assign div25_full = year_n * 12'd3113;
   assign div25_prod = div25_full[dtbe_pkg::YearW-1:0];
   assign div25      = (div25_prod <= 12'd163);
   assign leap       = (year_n[1:0] == 2'd0) && (!div25 || (year_n[3:0] == 4'd0));
   assign dim        = dtbe_pkg::month_days(leap, month_n);

   // Day clamped into the month.
   always_comb begin
      day_base = is_load ? item.load.day : dt_ff.day;
      if (day_base > dim) begin
         day_clamp = dim;
      end else if (day_base < dtbe_pkg::DAY_FIRST) begin
         day_clamp = dtbe_pkg::DAY_FIRST;
      end else begin
         day_clamp = day_base;
      end
   end

   // Next state of all fields.
   always_comb begin
      dt_in    = dt_ff;
      focus_in = focus_ff;
      save_in  = 1'b0;
      leave_in = 1'b0;
      case (item.func)
         dtbe_pkg::FUNC_LEFT: begin
            if (nav) begin
               focus_in = (focus_ff == dtbe_pkg::FOCUS_YEAR) ? dtbe_pkg::FOCUS_MINUTE
                                                             : focus_ff - 3'd1;
            end
         end
         dtbe_pkg::FUNC_RIGHT: begin
            if (nav) begin
               focus_in = (focus_ff >= dtbe_pkg::FOCUS_MINUTE) ? dtbe_pkg::FOCUS_YEAR
                                                               : focus_ff + 3'd1;
            end
         end
         dtbe_pkg::FUNC_UP, dtbe_pkg::FUNC_DOWN: begin
            if (nav) begin
               case (focus_ff)
                  dtbe_pkg::FOCUS_YEAR, dtbe_pkg::FOCUS_MONTH: begin
                     dt_in.year  = year_n;
                     dt_in.month = month_n;
                     dt_in.day   = day_clamp;
                  end
                  dtbe_pkg::FOCUS_DAY: begin
                     if (adj_up) begin
                        dt_in.day = (dt_ff.day >= dim) ? dtbe_pkg::DAY_FIRST
                                                       : dt_ff.day + 5'd1;
                     end else begin
                        dt_in.day = (dt_ff.day <= dtbe_pkg::DAY_FIRST) ? dim
                                                                       : dt_ff.day - 5'd1;
                     end
                  end
                  dtbe_pkg::FOCUS_HOUR: begin
                     if (adj_up) begin
                        dt_in.hour = (dt_ff.hour >= dtbe_pkg::HOUR_LAST) ? '0
                                                                         : dt_ff.hour + 5'd1;
                     end else begin
                        dt_in.hour = (dt_ff.hour == '0) ? dtbe_pkg::HOUR_LAST
                                                        : dt_ff.hour - 5'd1;
                     end
                  end
                  dtbe_pkg::FOCUS_MINUTE: begin
                     if (adj_up) begin
                        dt_in.minute = (dt_ff.minute >= dtbe_pkg::MINUTE_LAST) ? '0
                                                                 : dt_ff.minute + 6'd1;
                     end else begin
                        dt_in.minute = (dt_ff.minute == '0) ? dtbe_pkg::MINUTE_LAST
                                                            : dt_ff.minute - 6'd1;
                     end
                  end
                  default: begin
                     dt_in = dt_ff;
                  end
               endcase
            end
         end
         dtbe_pkg::FUNC_OK: begin
            save_in = press;
         end
         dtbe_pkg::FUNC_BACK: begin
            leave_in = press;
         end
         dtbe_pkg::FUNC_LOAD: begin
            dt_in.year   = year_n;
            dt_in.month  = month_n;
            dt_in.day    = day_clamp;
            dt_in.hour   = (item.load.hour > dtbe_pkg::HOUR_LAST) ? dtbe_pkg::HOUR_LAST
                                                                  : item.load.hour;
            dt_in.minute = (item.load.minute > dtbe_pkg::MINUTE_LAST) ? dtbe_pkg::MINUTE_LAST
                                                                      : item.load.minute;
            focus_in     = dtbe_pkg::FOCUS_YEAR;
         end
         default: begin
            dt_in = dt_ff;
         end
      endcase
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         year_low_ff  <= dtbe_pkg::YEAR_LOW_RESET;
         year_high_ff <= dtbe_pkg::YEAR_HIGH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            dtbe_pkg::CSR_YEAR_LOW:  year_low_ff  <= csr_wdata;
            dtbe_pkg::CSR_YEAR_HIGH: year_high_ff <= csr_wdata;
            default: begin
               year_low_ff <= year_low_ff;
            end
         endcase
      end
   end

   // State update on each accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff.year   <= dtbe_pkg::YEAR_RESET;
         dt_ff.month  <= dtbe_pkg::MONTH_RESET;
         dt_ff.day    <= dtbe_pkg::DAY_RESET;
         dt_ff.hour   <= dtbe_pkg::HOUR_RESET;
         dt_ff.minute <= dtbe_pkg::MINUTE_RESET;
         focus_ff     <= dtbe_pkg::FOCUS_YEAR;
         save_ff      <= 1'b0;
         leave_ff     <= 1'b0;
      end else if (take) begin
         dt_ff    <= dt_in;
         focus_ff <= focus_in;
         save_ff  <= save_in;
         leave_ff <= leave_in;
      end
   end

   assign result.dt    = dt_ff;
   assign result.focus = focus_ff;
   assign result.save  = save_ff;
   assign result.leave = leave_ff;

endmodule

@@ src/dtbe_weekday.sv @@
// Gregorian weekday of a date by the month-offset method, without dividers.
// Depends on dtbe_pkg.
module dtbe_weekday (
   input  dtbe_pkg::date_time_type             dt,
   output logic [dtbe_pkg::WeekdayW-1:0]       weekday
);

   logic [12:0] yy;
   logic [25:0] q100_prod;
   logic [6:0]  q100;
   logic [4:0]  q400;
   logic [10:0] q4;
   logic [13:0] sum;
   logic [4:0]  fold1;
   logic [3:0]  fold2;
   logic [3:0]  fold3;

   // Year shifted by 400 so that the January and February borrow never underflows.
   assign yy = {1'b0, dt.year} + 13'd400 - {12'd0, (dt.month < 4'd3)};

   // Floor by 100 through a reciprocal; exact for all 13-bit values.
   assign q100_prod = yy * 13'd5243;
   assign q100      = q100_prod[25:19];
   assign q400      = q100[6:2];
   assign q4        = yy[12:2];

   assign sum = {1'b0, yy} + {3'd0, q4} - {7'd0, q100} + {9'd0, q400}
              + {11'd0, dtbe_pkg::month_offset(dt.month)} + {9'd0, dt.day};

   // Remainder by 7: fold octal digits, since 8 is 1 modulo 7.
   assign fold1 = {2'd0, sum[2:0]} + {2'd0, sum[5:3]} + {2'd0, sum[8:6]}
                + {2'd0, sum[11:9]} + {3'd0, sum[13:12]};
   assign fold2 = {1'b0, fold1[2:0]} + {2'd0, fold1[4:3]};
   assign fold3 = {1'b0, fold2[2:0]} + {3'd0, fold2[3]};

   assign weekday = (fold3 >= 4'd7) ? fold3[2:0] - 3'd7 : fold3[2:0];

endmodule

@@ src/date_time_button_editor.sv @@
// Top level of the date and time editor: input stage, output register and
// handshakes. Depends on dtbe_pkg, dtbe_edit and dtbe_weekday.
//
// Usage:
//   The req_ channel carries one button event per transaction (function,
//   action and the values for a load). The rsp_ channel returns exactly one
//   result per event: the edited date and time, the focus, the weekday and
//   the save and exit pulses. The csr_ port writes the year bounds
//   (index 0 lower bound, index 1 upper bound) whenever csr_we is high; write
//   them only while no transaction is in flight.
//   Flow: an accepted event updates the editor state register, and the
//   weekday is then worked out from that state into the output register.
//   Throughput: one event per cycle while the output register is empty or
//   rsp_ready is high.
//   Reset: the date is 2020-01-01 00:00, focus is on the year, the bounds
//   are 2020 and 2099, and both stages are empty.
//   Stall: while rsp_ready is low the output register holds its result; one
//   more event can still be accepted into the state stage before req_ready
//   falls.
module date_time_button_editor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [dtbe_pkg::FuncW-1:0]          req_func,
   input  logic [dtbe_pkg::ActionW-1:0]        req_action,
   input  logic [dtbe_pkg::YearW-1:0]          req_load_year,
   input  logic [dtbe_pkg::MonthW-1:0]         req_load_month,
   input  logic [dtbe_pkg::DayW-1:0]           req_load_day,
   input  logic [dtbe_pkg::HourW-1:0]          req_load_hour,
   input  logic [dtbe_pkg::MinuteW-1:0]        req_load_minute,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dtbe_pkg::YearW-1:0]          rsp_year_out,
   output logic [dtbe_pkg::MonthW-1:0]         rsp_month_out,
   output logic [dtbe_pkg::DayW-1:0]           rsp_day_out,
   output logic [dtbe_pkg::HourW-1:0]          rsp_hour_out,
   output logic [dtbe_pkg::MinuteW-1:0]        rsp_minute_out,
   output logic [dtbe_pkg::FocusW-1:0]         rsp_focus_out,
   output logic [dtbe_pkg::WeekdayW-1:0]       rsp_weekday_out,
   output logic                                rsp_save_pulse,
   output logic                                rsp_exit_pulse,
   input  logic                                csr_we,
   input  logic [dtbe_pkg::CsrIndexW-1:0]      csr_index,
   input  logic [dtbe_pkg::CsrDataW-1:0]       csr_wdata
);

   dtbe_pkg::req_item_type      item;
   dtbe_pkg::edit_result_type   result;
   logic [dtbe_pkg::WeekdayW-1:0] weekday;

   logic                        edit_valid_ff, edit_valid_in;
   logic                        out_valid_ff, out_valid_in;
   logic                        take, out_ready, move;

   dtbe_pkg::edit_result_type     out_result_ff;
   logic [dtbe_pkg::WeekdayW-1:0] out_weekday_ff;

   // Pack the input transaction.
   assign item.func        = req_func;
   assign item.action      = req_action;
   assign item.load.year   = req_load_year;
   assign item.load.month  = req_load_month;
   assign item.load.day    = req_load_day;
   assign item.load.hour   = req_load_hour;
   assign item.load.minute = req_load_minute;

   // Handshake chain: each stage takes new data when empty or draining.
   assign out_ready = !out_valid_ff || rsp_ready;
   assign move      = edit_valid_ff && out_ready;
   assign req_ready = !edit_valid_ff || out_ready;
   assign take      = req_valid && req_ready;

   dtbe_edit u_edit (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .take      (take),
      .item      (item),
      .result    (result)
   );

   dtbe_weekday u_weekday (
      .dt      (result.dt),
      .weekday (weekday)
   );

   // Valid flags of the two stages.
   always_comb begin
      edit_valid_in = take || (edit_valid_ff && !move);
      out_valid_in  = move || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edit_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         edit_valid_ff <= edit_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (move) begin
         out_result_ff  <= result;
         out_weekday_ff <= weekday;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_year_out    = out_result_ff.dt.year;
   assign rsp_month_out   = out_result_ff.dt.month;
   assign rsp_day_out     = out_result_ff.dt.day;
   assign rsp_hour_out    = out_result_ff.dt.hour;
   assign rsp_minute_out  = out_result_ff.dt.minute;
   assign rsp_focus_out   = out_result_ff.focus;
   assign rsp_weekday_out = out_weekday_ff;
   assign rsp_save_pulse  = out_result_ff.save;
   assign rsp_exit_pulse  = out_result_ff.leave;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for date_time_button_editor: button events and year-bound writes
// are driven with random pacing, and every result is checked against a calendar predictor.
// Depends on dtbe_pkg and the date_time_button_editor RTL.
module testbench;
   import dtbe_pkg::*;

   // Codes that the package leaves unnamed but the ports can still carry.
   localparam logic [FuncW-1:0]   FUNC_SPARE = 3'd7;
   localparam logic [ActionW-1:0] ACT_SPARE  = 2'd3;

   localparam int IdlePercent  = 27;
   localparam int SettleCycles = 6;
   localparam int CycleLimit   = 200000;
   localparam int PrintLimit   = 200;

   // One editor result as the block should show it.
   typedef struct packed {
      logic [YearW-1:0]    year;
      logic [MonthW-1:0]   month;
      logic [DayW-1:0]     day;
      logic [HourW-1:0]    hour;
      logic [MinuteW-1:0]  minute;
      logic [FocusW-1:0]   focus;
      logic [WeekdayW-1:0] weekday;
      logic                save;
      logic                leave;
   } editor_view_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [FuncW-1:0]      req_func;
   logic [ActionW-1:0]    req_action;
   logic [YearW-1:0]      req_load_year;
   logic [MonthW-1:0]     req_load_month;
   logic [DayW-1:0]       req_load_day;
   logic [HourW-1:0]      req_load_hour;
   logic [MinuteW-1:0]    req_load_minute;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [YearW-1:0]      rsp_year_out;
   logic [MonthW-1:0]     rsp_month_out;
   logic [DayW-1:0]       rsp_day_out;
   logic [HourW-1:0]      rsp_hour_out;
   logic [MinuteW-1:0]    rsp_minute_out;
   logic [FocusW-1:0]     rsp_focus_out;
   logic [WeekdayW-1:0]   rsp_weekday_out;
   logic                  rsp_save_pulse;
   logic                  rsp_exit_pulse;
   logic                  csr_we;
   logic [CsrIndexW-1:0]  csr_index;
   logic [CsrDataW-1:0]   csr_wdata;

   // Predicted editor state and year bounds.
   logic [YearW-1:0]   cur_year = YEAR_RESET;
   logic [MonthW-1:0]  cur_month = MONTH_RESET;
   logic [DayW-1:0]    cur_day = DAY_RESET;
   logic [HourW-1:0]   cur_hour = HOUR_RESET;
   logic [MinuteW-1:0] cur_minute = MINUTE_RESET;
   logic [FocusW-1:0]  cur_focus = FOCUS_YEAR;
   logic [YearW-1:0]   bound_low = YEAR_LOW_RESET;
   logic [YearW-1:0]   bound_high = YEAR_HIGH_RESET;

   editor_view_type expected_views[$];
   editor_view_type want;
   bit steady = 1'b0;
   int mismatches = 0;
   int cycle_count = 0;
   int events_sent = 0;
   int loads_sent = 0;
   int results_seen = 0;
   int saves_seen = 0;
   int exits_seen = 0;
   int bound_settings = 0;

   date_time_button_editor uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_action(req_action),
      .req_load_year(req_load_year),
      .req_load_month(req_load_month),
      .req_load_day(req_load_day),
      .req_load_hour(req_load_hour),
      .req_load_minute(req_load_minute),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_year_out(rsp_year_out),
      .rsp_month_out(rsp_month_out),
      .rsp_day_out(rsp_day_out),
      .rsp_hour_out(rsp_hour_out),
      .rsp_minute_out(rsp_minute_out),
      .rsp_focus_out(rsp_focus_out),
      .rsp_weekday_out(rsp_weekday_out),
      .rsp_save_pulse(rsp_save_pulse),
      .rsp_exit_pulse(rsp_exit_pulse),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Gregorian month length, with the century leap rule.
   function automatic int unsigned days_in(input int unsigned y, input int unsigned m);
      bit leap;
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      case (m)
         2: return leap ? 29 : 28;
         4, 6, 9, 11: return 30;
         default: return 31;
      endcase
   endfunction

   // Weekday from the month-offset method; the year is shifted by 400 to stay positive.
   function automatic logic [WeekdayW-1:0] weekday_of(input int unsigned y,
                                                      input int unsigned m,
                                                      input int unsigned d);
      int unsigned yy;
      int unsigned offs;
      yy = y + 400;
      if (m < 3) yy = yy - 1;
      case (m)
         2: offs = 3;
         3: offs = 2;
         4: offs = 5;
         6: offs = 3;
         7: offs = 5;
         8: offs = 1;
         9: offs = 4;
         10: offs = 6;
         11: offs = 2;
         12: offs = 4;
         default: offs = 0;
      endcase
      return WeekdayW'((yy + yy / 4 - yy / 100 + yy / 400 + offs + d) % 7);
   endfunction

   // Pull the day back into the current month.
   function automatic void fit_to_month();
      int unsigned dim;
      dim = days_in(cur_year, cur_month);
      if (cur_day > dim) cur_day = DayW'(dim);
      if (cur_day < DAY_FIRST) cur_day = DAY_FIRST;
   endfunction

   // Add or subtract one on the focused field, with per-field wrap-around.
   function automatic void step_field(input bit up);
      int unsigned y;
      int unsigned dim;
      case (cur_focus)
         FOCUS_YEAR: begin
            // Below the lower bound goes to the upper one, and only then is the
            // upper bound tested; this also settles inverted bounds.
            if (up) y = cur_year + 1;
            else y = (cur_year == 0) ? bound_high : cur_year - 1;
            if (y < bound_low) y = bound_high;
            if (y > bound_high) y = bound_low;
            cur_year = y[YearW-1:0];
            fit_to_month();
         end
         FOCUS_MONTH: begin
            if (up) cur_month = (cur_month >= MONTH_LAST) ? MONTH_FIRST : cur_month + 4'd1;
            else cur_month = (cur_month <= MONTH_FIRST) ? MONTH_LAST : cur_month - 4'd1;
            fit_to_month();
         end
         FOCUS_DAY: begin
            dim = days_in(cur_year, cur_month);
            if (up) cur_day = (cur_day >= dim) ? DAY_FIRST : cur_day + 5'd1;
            else cur_day = (cur_day <= DAY_FIRST) ? DayW'(dim) : cur_day - 5'd1;
         end
         FOCUS_HOUR: begin
            if (up) cur_hour = (cur_hour >= HOUR_LAST) ? '0 : cur_hour + 5'd1;
            else cur_hour = (cur_hour == 0) ? HOUR_LAST : cur_hour - 5'd1;
         end
         FOCUS_MINUTE: begin
            if (up) cur_minute = (cur_minute >= MINUTE_LAST) ? '0 : cur_minute + 6'd1;
            else cur_minute = (cur_minute == 0) ? MINUTE_LAST : cur_minute - 6'd1;
         end
         default: ;
      endcase
   endfunction

   // Apply one button event to the predicted state and return the view it produces.
   function automatic editor_view_type apply_event(input req_item_type ev);
      editor_view_type view;
      bit press;
      bit nav;
      press = (ev.action == ACT_PRESS);
      nav = press || (ev.action == ACT_REPEAT);
      view.save = 1'b0;
      view.leave = 1'b0;
      case (ev.func)
         FUNC_LEFT:  if (nav) cur_focus = (cur_focus == FOCUS_YEAR) ? FOCUS_MINUTE
                                                                    : cur_focus - 3'd1;
         FUNC_RIGHT: if (nav) cur_focus = (cur_focus >= FOCUS_MINUTE) ? FOCUS_YEAR
                                                                      : cur_focus + 3'd1;
         FUNC_UP:    if (nav) step_field(1'b1);
         FUNC_DOWN:  if (nav) step_field(1'b0);
         FUNC_OK:    if (press) view.save = 1'b1;
         FUNC_BACK:  if (press) view.leave = 1'b1;
         FUNC_LOAD: begin
            // A load ignores the action and saturates out-of-range fields.
            cur_year = ev.load.year;
            cur_month = ev.load.month;
            if (cur_month < MONTH_FIRST) cur_month = MONTH_FIRST;
            if (cur_month > MONTH_LAST) cur_month = MONTH_LAST;
            cur_day = ev.load.day;
            cur_hour = (ev.load.hour > HOUR_LAST) ? HOUR_LAST : ev.load.hour;
            cur_minute = (ev.load.minute > MINUTE_LAST) ? MINUTE_LAST : ev.load.minute;
            fit_to_month();
            cur_focus = FOCUS_YEAR;
         end
         default: ;
      endcase
      view.year = cur_year;
      view.month = cur_month;
      view.day = cur_day;
      view.hour = cur_hour;
      view.minute = cur_minute;
      view.focus = cur_focus;
      view.weekday = weekday_of(cur_year, cur_month, cur_day);
      return view;
   endfunction

   // Button event without load values.
   function automatic req_item_type key(input logic [FuncW-1:0] func,
                                        input logic [ActionW-1:0] action);
      req_item_type ev;
      ev = '0;
      ev.func = func;
      ev.action = action;
      return ev;
   endfunction

   // Load event with the given date and time.
   function automatic req_item_type load_event(input logic [ActionW-1:0] action,
                                               input int unsigned y, input int unsigned m,
                                               input int unsigned d, input int unsigned h,
                                               input int unsigned mi);
      req_item_type ev;
      ev = key(FUNC_LOAD, action);
      ev.load.year = YearW'(y);
      ev.load.month = MonthW'(m);
      ev.load.day = DayW'(d);
      ev.load.hour = HourW'(h);
      ev.load.minute = MinuteW'(mi);
      return ev;
   endfunction

   // Mostly navigation and edits with plausible loads; a share of releases, spare codes
   // and out-of-range load values.
   function automatic req_item_type random_event();
      req_item_type ev;
      int pick;
      bit wild;
      pick = $urandom_range(99);
      if (pick < 24) ev.func = $urandom_range(1) ? FUNC_RIGHT : FUNC_LEFT;
      else if (pick < 64) ev.func = $urandom_range(1) ? FUNC_UP : FUNC_DOWN;
      else if (pick < 72) ev.func = FUNC_OK;
      else if (pick < 78) ev.func = FUNC_BACK;
      else if (pick < 96) ev.func = FUNC_LOAD;
      else ev.func = FUNC_SPARE;
      pick = $urandom_range(99);
      if (pick < 55) ev.action = ACT_PRESS;
      else if (pick < 85) ev.action = ACT_REPEAT;
      else if (pick < 96) ev.action = ACT_RELEASE;
      else ev.action = ACT_SPARE;
      wild = ($urandom_range(7) == 0);
      pick = $urandom_range(2);
      if (wild) ev.load.year = YearW'($urandom);
      else if (pick == 0) ev.load.year = YearW'($urandom_range(bound_low, bound_high));
      else ev.load.year = YearW'($urandom_range(1970, 2099));
      ev.load.month = MonthW'(wild ? $urandom_range(15) : $urandom_range(1, 12));
      ev.load.day = DayW'(wild ? $urandom_range(31) : $urandom_range(1, 31));
      ev.load.hour = HourW'(wild ? $urandom_range(31) : $urandom_range(0, 23));
      ev.load.minute = MinuteW'(wild ? $urandom_range(63) : $urandom_range(0, 59));
      return ev;
   endfunction

   // Send one event; entered and left at a falling edge. Valid stays high after the
   // transaction so back-to-back events keep it asserted.
   task automatic send_event(input req_item_type ev);
      int gap;
      if (!steady && $urandom_range(99) < IdlePercent) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= ev.func;
      req_action <= ev.action;
      req_load_year <= ev.load.year;
      req_load_month <= ev.load.month;
      req_load_day <= ev.load.day;
      req_load_hour <= ev.load.hour;
      req_load_minute <= ev.load.minute;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_views.push_back(apply_event(ev));
      events_sent++;
      if (ev.func == FUNC_LOAD) loads_sent++;
      @(negedge clock);
   endtask

   task automatic run_random(input int count);
      repeat (count) send_event(random_event());
   endtask

   // Hold the sender until every result is back, then let the pipeline settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_views.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   // Write both year bounds while the block is idle.
   task automatic change_bounds(input logic [YearW-1:0] low, input logic [YearW-1:0] high);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= CSR_YEAR_LOW;
      csr_wdata <= low;
      @(negedge clock);
      csr_index <= CSR_YEAR_HIGH;
      csr_wdata <= high;
      @(negedge clock);
      csr_we <= 1'b0;
      bound_low = low;
      bound_high = high;
      bound_settings++;
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_val);
      mismatches++;
      if (mismatches <= PrintLimit)
         $display("MISMATCH cycle %0d result %0d: %s got %0d, expected %0d",
                  cycle_count, results_seen, what, got, exp_val);
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] exp_val);
      if (got !== exp_val) report(what, got, exp_val);
   endtask

   // Result side: random back-pressure unless in a steady stretch.
   initial rsp_ready = 1'b0;
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IdlePercent);
   end

   // Compare every result transaction with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_views.size() == 0) begin
            report("unexpected result, valid", 1, 0);
         end else begin
            want = expected_views.pop_front();
            check_field("year_out", 32'(rsp_year_out), 32'(want.year));
            check_field("month_out", 32'(rsp_month_out), 32'(want.month));
            check_field("day_out", 32'(rsp_day_out), 32'(want.day));
            check_field("hour_out", 32'(rsp_hour_out), 32'(want.hour));
            check_field("minute_out", 32'(rsp_minute_out), 32'(want.minute));
            check_field("focus_out", 32'(rsp_focus_out), 32'(want.focus));
            check_field("weekday_out", 32'(rsp_weekday_out), 32'(want.weekday));
            check_field("save_pulse", 32'(rsp_save_pulse), 32'(want.save));
            check_field("exit_pulse", 32'(rsp_exit_pulse), 32'(want.leave));
            if (want.save) saves_seen++;
            if (want.leave) exits_seen++;
         end
         results_seen++;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, expected_views.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // Events that change nothing must still return the reset view.
   task automatic test_reset_view();
      send_event(key(FUNC_UP, ACT_RELEASE));
      send_event(key(FUNC_SPARE, ACT_PRESS));
      send_event(key(FUNC_LEFT, ACT_SPARE));
   endtask

   // Field extremes, year wrap, leap days, day clamping and every function code.
   task automatic test_directed_edits();
      send_event(load_event(ACT_PRESS, 2024, 2, 29, 23, 59));
      // A year step off a leap day clamps to the 28th.
      send_event(key(FUNC_UP, ACT_PRESS));
      // A load acts on release as well.
      send_event(load_event(ACT_RELEASE, 2099, 12, 31, 0, 0));
      send_event(key(FUNC_UP, ACT_PRESS));
      send_event(key(FUNC_DOWN, ACT_REPEAT));
      // Loads with zero or all-ones fields saturate month, hour and minute.
      send_event(load_event(ACT_SPARE, 0, 0, 0, 31, 63));
      send_event(key(FUNC_DOWN, ACT_PRESS));
      send_event(load_event(ACT_PRESS, 4095, 15, 31, 5, 30));
      send_event(key(FUNC_UP, ACT_REPEAT));
      // A century year that is not a leap year.
      send_event(load_event(ACT_PRESS, 1900, 2, 29, 12, 0));
      send_event(load_event(ACT_PRESS, 2000, 3, 31, 23, 59));
      // Focus wraps both ways.
      send_event(key(FUNC_LEFT, ACT_PRESS));
      send_event(key(FUNC_UP, ACT_PRESS));
      send_event(key(FUNC_DOWN, ACT_PRESS));
      send_event(key(FUNC_RIGHT, ACT_PRESS));
      send_event(key(FUNC_RIGHT, ACT_REPEAT));
      // March 31st of a 400-year leap year stepped back to February 29th.
      send_event(key(FUNC_DOWN, ACT_PRESS));
      send_event(key(FUNC_RIGHT, ACT_PRESS));
      send_event(key(FUNC_UP, ACT_PRESS));
      send_event(key(FUNC_DOWN, ACT_PRESS));
      send_event(key(FUNC_RIGHT, ACT_PRESS));
      send_event(key(FUNC_UP, ACT_PRESS));
      send_event(key(FUNC_OK, ACT_PRESS));
      send_event(key(FUNC_OK, ACT_REPEAT));
      send_event(key(FUNC_BACK, ACT_PRESS));
      send_event(key(FUNC_BACK, ACT_RELEASE));
   endtask

   // Random traffic under a range of year bounds, including inverted and degenerate ones.
   task automatic test_year_bounds();
      logic [YearW-1:0] low;
      logic [YearW-1:0] high;
      for (int s = 0; s < 8; s++) begin
         case (s)
            0: begin low = 12'd1970; high = 12'd2099; end
            1: begin low = '0; high = '1; end
            2: begin low = '1; high = '0; end
            3: begin low = 12'd2030; high = 12'd2025; end
            4: begin low = 12'd2000; high = 12'd2000; end
            5: begin low = 12'd2022; high = 12'd2024; end
            6: begin low = '0; high = '0; end
            default: begin
               low = YearW'($urandom_range(1970, 2099));
               high = YearW'($urandom_range(low, 2099));
            end
         endcase
         change_bounds(low, high);
         run_random(170);
      end
   endtask

   // A long stretch with neither side idling.
   task automatic test_steady_stream();
      change_bounds(YEAR_LOW_RESET, YEAR_HIGH_RESET);
      steady = 1'b1;
      run_random(250);
      steady = 1'b0;
   endtask

   // The sender stops until the pipeline has drained, then resumes.
   task automatic test_drain_pause();
      run_random(100);
      wait_idle();
      run_random(100);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_LEFT;
      req_action = ACT_PRESS;
      req_load_year = '0;
      req_load_month = '0;
      req_load_day = '0;
      req_load_hour = '0;
      req_load_minute = '0;
      csr_we = 1'b0;
      csr_index = CSR_YEAR_LOW;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_view();
      test_directed_edits();
      test_year_bounds();
      test_steady_stream();
      test_drain_pause();
      wait_idle();

      $display("Run covered %0d button events (%0d loads) and %0d year-bound settings.",
               events_sent, loads_sent, bound_settings);
      $display("Checked %0d results, %0d with a save pulse and %0d with an exit pulse.",
               results_seen, saves_seen, exits_seen);
      if (mismatches == 0 && expected_views.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/dtbe_pkg.sv
src/dtbe_edit.sv
src/dtbe_weekday.sv
src/date_time_button_editor.sv
bench/testbench.sv
